[design/trial_division_factorizer_defines.svh]
// assertion macros shared by the trial division factorizer modules
// depends on nothing; included by the modules that carry assertions
`ifndef TRIAL_DIVISION_FACTORIZER_DEFINES_SVH
`define TRIAL_DIVISION_FACTORIZER_DEFINES_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define TDF_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
// condition that must never be true outside reset
`define TDF_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("forbidden condition seen");
`else
`define TDF_ASSERT(label, clk, rstn, prop)
`define TDF_NEVER(label, clk, rstn, expr)
`endif
`endif

[design/tdf_pkg.sv]
// types and constants of the trial division factorizer
// depends on nothing; used by every module of the block except tdf_div
`default_nettype none
package tdf_pkg;

    localparam int VALUE_W     = 32;
    localparam int PRIME_W     = 32;
    localparam int EXP_W       = 5;
    localparam int OUT_TDATA_W = 40;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [EXP_W-1:0] EXP_MAX = 5'd31;

    // item kind decided by the front part
    typedef enum logic {
        KIND_ONE,
        KIND_FULL
    } kind_t;

    // one queued item
    typedef struct packed {
        kind_t              kind;
        logic [VALUE_W-1:0] value;
    } item_t;

    // one result item
    typedef struct packed {
        logic [PRIME_W-1:0] prime;
        logic [EXP_W-1:0]   exponent;
        logic               last;
        logic               none;
    } result_t;

    // back part sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT
    } back_state_t;

endpackage
`default_nettype wire

[design/tdf_front.sv]
// front part: input register and classification of each item
// depends on tdf_pkg
`default_nettype none
module tdf_front #(
    parameter int WIDTH = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [tdf_pkg::VALUE_W-1:0]  s_value,
    output logic                              push_valid,
    input  wire logic                         push_ready,
    output tdf_pkg::item_t                    push_item
);

    logic                            valid_reg;
    logic                            valid_next;
    tdf_pkg::item_t                  item_reg;
    logic [WIDTH+tdf_pkg::VALUE_W-1:0] value_ext;
    logic [WIDTH-1:0]                value_used;
    logic                            is_one;

    // only the low WIDTH bits count
    assign value_ext  = {{WIDTH{1'b0}}, s_value};
    assign value_used = value_ext[WIDTH-1:0];
    assign is_one     = (value_used == {{(WIDTH-1){1'b0}}, 1'b1});

    assign s_tready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    // stage valid
    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (push_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // classified payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.kind  <= is_one ? tdf_pkg::KIND_ONE : tdf_pkg::KIND_FULL;
            item_reg.value <= s_value;
        end
    end

endmodule
`default_nettype wire

[design/tdf_queue.sv]
// short queue between the front and the back part
// depends on tdf_pkg
`default_nettype none
module tdf_queue (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push_valid,
    output logic          push_ready,
    input  wire tdf_pkg::item_t push_item,
    output logic          pop_valid,
    input  wire logic     pop_ready,
    output tdf_pkg::item_t pop_item
);

    localparam int PTR_W = $clog2(tdf_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(tdf_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(tdf_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(tdf_pkg::QUEUE_DEPTH - 1);

    tdf_pkg::item_t   mem [tdf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

[design/tdf_div.sv]
// restoring divider, one quotient bit per cycle
// depends on nothing; used by tdf_back
`default_nettype none
module tdf_div #(
    parameter int WIDTH = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] dividend,
    input  wire logic [WIDTH-1:0] divisor,
    output logic                  done,
    output logic [WIDTH-1:0]      quotient,
    output logic [WIDTH-1:0]      remainder
);

    localparam int STEP_W = $clog2(WIDTH + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WIDTH);

    logic [WIDTH-1:0]  rem_reg;
    logic [WIDTH-1:0]  rem_next;
    logic [WIDTH-1:0]  quo_reg;
    logic [WIDTH-1:0]  quo_next;
    logic [WIDTH-1:0]  dvs_reg;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [WIDTH:0]    trial;
    logic [WIDTH:0]    diff;
    logic              fits;

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    // one shift and subtract step
    assign trial = {rem_reg, quo_reg[WIDTH-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            quo_next  = {quo_reg[WIDTH-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP - 1'b1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

endmodule
`default_nettype wire

[design/tdf_back.sv]
// back part: trial division sequencer and result output register
// depends on tdf_pkg, tdf_div and trial_division_factorizer_defines.svh
`default_nettype none
`include "trial_division_factorizer_defines.svh"
module tdf_back #(
    parameter int WIDTH = 32
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      pop_valid,
    output logic           pop_ready,
    input  wire tdf_pkg::item_t pop_item,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    output tdf_pkg::result_t m_result
);

    localparam int CAND_W = WIDTH / 2 + 2;
    localparam logic [CAND_W-1:0] FIRST_CAND = CAND_W'(2);
    localparam logic [WIDTH-1:0]  ONE_W = {{(WIDTH-1){1'b0}}, 1'b1};

    tdf_pkg::back_state_t state_reg;
    tdf_pkg::back_state_t state_next;

    logic [WIDTH-1:0]            n_reg;
    logic [WIDTH-1:0]            n_next;
    logic [CAND_W-1:0]           c_reg;
    logic [CAND_W-1:0]           c_next;
    logic [tdf_pkg::EXP_W-1:0]   cnt_reg;
    logic [tdf_pkg::EXP_W-1:0]   cnt_next;
    logic                        inner_reg;
    logic                        inner_next;
    logic                        fin_reg;
    logic                        fin_next;
    tdf_pkg::result_t            res_reg;
    tdf_pkg::result_t            res_next;
    logic                        m_valid_reg;
    logic                        m_valid_next;
    tdf_pkg::result_t            m_res_reg;
    tdf_pkg::result_t            m_res_next;

    logic                        div_start;
    logic                        div_done;
    logic [WIDTH-1:0]            div_q;
    logic [WIDTH-1:0]            div_r;
    logic [WIDTH+CAND_W-1:0]     c_ext;
    logic [WIDTH-1:0]            c_full;
    logic [WIDTH+tdf_pkg::VALUE_W-1:0] v_ext;
    logic [WIDTH+tdf_pkg::PRIME_W-1:0] n_pext;
    logic [CAND_W+tdf_pkg::PRIME_W-1:0] c_pext;
    logic [tdf_pkg::PRIME_W-1:0] n_prime;
    logic [tdf_pkg::PRIME_W-1:0] c_prime;
    logic                        past_root;
    logic                        r_zero;
    logic                        n_is_one;
    logic                        emit_dec;
    logic                        quiet_dec;
    logic                        out_free;
    logic [tdf_pkg::EXP_W-1:0]   cnt_inc;

    tdf_div #(
        .WIDTH(WIDTH)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (n_reg),
        .divisor  (c_full),
        .done     (div_done),
        .quotient (div_q),
        .remainder(div_r)
    );

    // width adaption
    assign c_ext   = {{WIDTH{1'b0}}, c_reg};
    assign c_full  = c_ext[WIDTH-1:0];
    assign v_ext   = {{WIDTH{1'b0}}, pop_item.value};
    assign n_pext  = {{tdf_pkg::PRIME_W{1'b0}}, n_reg};
    assign c_pext  = {{tdf_pkg::PRIME_W{1'b0}}, c_reg};
    assign n_prime = n_pext[tdf_pkg::PRIME_W-1:0];
    assign c_prime = c_pext[tdf_pkg::PRIME_W-1:0];

    // decisions on a finished division
    assign past_root = (c_full > div_q);
    assign r_zero    = (div_r == '0);
    assign n_is_one  = (n_reg == ONE_W);
    assign emit_dec  = inner_reg ? !r_zero : (past_root && !n_is_one);
    assign quiet_dec = !inner_reg && past_root && n_is_one;
    assign out_free  = !m_valid_reg || m_tready;
    assign cnt_inc   = (cnt_reg == tdf_pkg::EXP_MAX) ? cnt_reg : cnt_reg + 1'b1;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tdf_pkg::ST_IDLE: begin
                if (pop_valid) begin
                    state_next = (pop_item.kind == tdf_pkg::KIND_ONE) ?
                                 tdf_pkg::ST_EMIT : tdf_pkg::ST_DIV_START;
                end
            end
            tdf_pkg::ST_DIV_START: begin
                state_next = tdf_pkg::ST_DIV_WAIT;
            end
            tdf_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    if (emit_dec) begin
                        state_next = tdf_pkg::ST_EMIT;
                    end else if (quiet_dec) begin
                        state_next = tdf_pkg::ST_IDLE;
                    end else begin
                        state_next = tdf_pkg::ST_DIV_START;
                    end
                end
            end
            tdf_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = fin_reg ? tdf_pkg::ST_IDLE : tdf_pkg::ST_DIV_START;
                end
            end
            default: begin
                state_next = tdf_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and working values
    always_comb begin
        pop_ready    = 1'b0;
        div_start    = 1'b0;
        n_next       = n_reg;
        c_next       = c_reg;
        cnt_next     = cnt_reg;
        inner_next   = inner_reg;
        fin_next     = fin_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            tdf_pkg::ST_IDLE: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    n_next     = v_ext[WIDTH-1:0];
                    c_next     = FIRST_CAND;
                    cnt_next   = '0;
                    inner_next = 1'b0;
                    fin_next   = 1'b1;
                    res_next   = '{prime: '0, exponent: '0, last: 1'b1, none: 1'b1};
                end
            end
            tdf_pkg::ST_DIV_START: begin
                div_start = 1'b1;
            end
            tdf_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    if (!inner_reg) begin
                        if (past_root) begin
                            // leftover part is itself prime
                            fin_next = 1'b1;
                            res_next = '{prime: n_prime, exponent: tdf_pkg::EXP_W'(1),
                                         last: 1'b1, none: 1'b0};
                        end else if (!r_zero) begin
                            c_next = c_reg + 1'b1;
                        end else begin
                            n_next     = div_q;
                            cnt_next   = tdf_pkg::EXP_W'(1);
                            inner_next = 1'b1;
                        end
                    end else if (r_zero) begin
                        n_next   = div_q;
                        cnt_next = cnt_inc;
                    end else begin
                        // candidate fully divided out; nothing follows once n is one
                        fin_next   = n_is_one;
                        inner_next = 1'b0;
                        c_next     = c_reg + 1'b1;
                        res_next   = '{prime: c_prime, exponent: cnt_reg,
                                       last: n_is_one, none: 1'b0};
                    end
                end
            end
            tdf_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_res_next   = res_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tdf_pkg::ST_IDLE;
            inner_reg   <= 1'b0;
            fin_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            inner_reg   <= inner_next;
            fin_reg     <= fin_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        c_reg     <= c_next;
        cnt_reg   <= cnt_next;
        res_reg   <= res_next;
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_result = m_res_reg;

    // checks
    `TDF_NEVER(a_cand_low, aclk, aresetn,
        (state_reg != tdf_pkg::ST_IDLE) && (c_reg < FIRST_CAND))
    `TDF_ASSERT(a_none_last, aclk, aresetn,
        (m_valid_reg && m_res_reg.none) |-> m_res_reg.last)
    `TDF_NEVER(a_inner_zero, aclk, aresetn,
        inner_reg && (state_reg != tdf_pkg::ST_IDLE) && (n_reg == '0))

endmodule
`default_nettype wire

[design/trial_division_factorizer.sv]
// top level of the trial division factorizer
// depends on tdf_pkg, tdf_front, tdf_queue and tdf_back
`default_nettype none
// Factors each unsigned input value by trial division and streams out one
// result per distinct prime with its exponent, ascending, the final result
// of each value marked by m_tlast; an input of one gives a single result with
// m_tuser set, an input of zero gives prime zero with exponent one. Each
// candidate is tried by dividing the unfactored part on a restoring divider
// that yields one quotient bit per cycle; a candidate that divides it is
// divided out again until a remainder is left, and the search ends once
// the candidate exceeds the quotient. The front stage and a two-entry queue
// take new values while a value is being worked.
module trial_division_factorizer #(
    parameter int WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // value[31:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // prime[31:0], exponent[36:32], zero[39:37]
    output logic             m_tlast,
    output logic             m_tuser    // none
);

    logic             push_valid;
    logic             push_ready;
    tdf_pkg::item_t   push_item;
    logic             pop_valid;
    logic             pop_ready;
    tdf_pkg::item_t   pop_item;
    tdf_pkg::result_t result;

    tdf_front #(
        .WIDTH(WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_value   (s_tdata),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_item (push_item)
    );

    tdf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_item (push_item),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item)
    );

    tdf_back #(
        .WIDTH(WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_item (pop_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (result)
    );

    // result packing
    assign m_tdata = {3'b000, result.exponent, result.prime};
    assign m_tlast = result.last;
    assign m_tuser = result.none;

endmodule
`default_nettype wire
